### rtl/core/phc_pkg.sv
`default_nettype none

package phc_pkg;

  // Link layer constants.
  localparam logic [15:0] TPID_VLAN     = 16'h8100;
  localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6    = 16'h86DD;
  localparam logic [15:0] ETYPE_ARP     = 16'h0806;
  localparam logic [4:0]  ETH_LEN       = 5'd14;
  localparam logic [4:0]  VLAN_ETH_LEN  = 5'd18;

  // Network layer constants.
  localparam logic [5:0]  IP4_MIN_HDR   = 6'd20;
  localparam logic [6:0]  IP6_HDR_LEN   = 7'd40;

  // Transport header minimum lengths.
  localparam logic [8:0]  TCP_MIN_HDR   = 9'd20;
  localparam logic [8:0]  UDP_HDR_LEN   = 9'd8;
  localparam logic [8:0]  ICMP_HDR_LEN  = 9'd8;

  // Protocol numbers.
  localparam logic [7:0]  PROTO_ICMP    = 8'd1;
  localparam logic [7:0]  PROTO_TCP     = 8'd6;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [7:0]  PROTO_ICMP6   = 8'd58;

  // Well-known ports for the application mask.
  localparam logic [15:0] PORT_DNS      = 16'd53;
  localparam logic [15:0] PORT_DHCP_S   = 16'd67;
  localparam logic [15:0] PORT_DHCP_C   = 16'd68;
  localparam logic [15:0] PORT_HTTP     = 16'd80;
  localparam logic [15:0] PORT_FTP      = 16'd21;
  localparam logic [15:0] PORT_SMTP     = 16'd25;

  // Network layer kind codes.
  localparam logic [2:0]  KIND_NONE     = 3'd0;
  localparam logic [2:0]  KIND_IPV4     = 3'd1;
  localparam logic [2:0]  KIND_IPV6     = 3'd2;
  localparam logic [2:0]  KIND_ARP      = 3'd3;
  localparam logic [2:0]  KIND_OTHER    = 3'd4;

  // Status codes.
  localparam logic [1:0]  STAT_OK       = 2'd0;
  localparam logic [1:0]  STAT_SHORT_L2 = 2'd1;
  localparam logic [1:0]  STAT_SHORT_L3 = 2'd2;
  localparam logic [1:0]  STAT_SHORT_L4 = 2'd3;

  // Application mask bits.
  localparam int APP_DNS  = 0;
  localparam int APP_DHCP = 1;
  localparam int APP_HTTP = 2;
  localparam int APP_FTP  = 3;
  localparam int APP_SMTP = 4;

  // Widths of the packed result item and of the output bus, padded to whole bytes.
  localparam int RES_W  = 100;
  localparam int TDATA_OUT_W = 104;

  // Per-frame parse state.
  typedef struct packed {
    logic [7:0]  pos;
    logic [15:0] ether_type;
    logic [4:0]  link_len;
    logic [2:0]  kind;
    logic [5:0]  ihl_len;
    logic [7:0]  proto;
    logic [6:0]  l4_off;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [5:0]  tcp_len;
    logic [5:0]  flags;
    logic [15:0] icmp_bytes;
    logic [7:0]  vlan_hi;
  } parse_state_t;

  // Tracker view handed to the result logic: state after the current byte
  // and the frame length counted through that byte.
  typedef struct packed {
    logic [8:0]   frame_len;
    parse_state_t hdr;
  } track_t;

  // One result item; the last member sits in the lowest bits.
  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  app_mask;
    logic [7:0]  icmp_subcode;
    logic [7:0]  icmp_kind;
    logic [5:0]  tcp_flag_bits;
    logic [15:0] dest_port;
    logic [15:0] source_port;
    logic [6:0]  l4_offset;
    logic [7:0]  l4_protocol;
    logic [2:0]  l3_kind;
    logic [4:0]  l2_length;
    logic [15:0] ether_type;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/packet_header_classifier.sv
// Packet header classifier.
// Input stream: one frame byte per transfer on in_tdata[7:0], wire order from
// the destination MAC onward; in_tlast marks the final captured byte.
// Output stream: one result transfer per frame, carrying Ethernet type, link
// header length, network kind, transport protocol and offset, ports, TCP
// flags, ICMP type and code, an application mask and a truncation status.
// A frame's last byte passes the input register, its result the result register.
// Throughput: one byte per cycle, frames back to back with no gap, unless a
// last byte waits on a full result register. Every byte passes through the
// same single stage of parse logic between the two registers, so the rate
// does not depend on frame contents.
// Reset: rst_n clears the input and result valid flags and the per-frame
// parse state; the first byte after reset starts a new frame.
// Stall: while out_tready is low and a result waits, non-last bytes keep
// flowing; a last byte is held in the input register until the result
// register frees, and in_tready drops only then.
`default_nettype none

module packet_header_classifier (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // Input channel.
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] data_byte
  input  wire logic         in_tlast,
  // Result channel.
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [103:0]      out_tdata   // [15:0] ether_type, [20:16] l2_length,
                                        // [23:21] l3_kind, [31:24] l4_protocol,
                                        // [38:32] l4_offset, [54:39] source_port,
                                        // [70:55] dest_port, [76:71] tcp_flag_bits,
                                        // [84:77] icmp_kind, [92:85] icmp_subcode,
                                        // [97:93] app_mask, [99:98] status, rest 0
);

  logic              in_valid_r;
  logic [7:0]        in_data_r;
  logic              in_last_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  phc_pkg::result_t  out_data_r;
  phc_pkg::result_t  res_c;
  phc_pkg::track_t   trk_c;
  logic              out_free_c;
  logic              consume_c;
  logic              load_out_c;

  // Handshake: a byte leaves the input register unless it is a last byte
  // facing a full result register.
  assign out_free_c = !out_valid_r || out_tready;
  assign consume_c  = in_valid_r && (!in_last_r || out_free_c);
  assign load_out_c = consume_c && in_last_r;
  assign in_tready  = !in_valid_r || consume_c;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // Per-frame header state.
  phc_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (consume_c),
    .data_byte (in_data_r),
    .last      (in_last_r),
    .trk       (trk_c)
  );

  // Result formation.
  phc_result u_result (
    .trk (trk_c),
    .res (res_c)
  );

  // Result register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out_c) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out_c) begin
      out_data_r <= res_c;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(phc_pkg::TDATA_OUT_W - phc_pkg::RES_W){1'b0}}, out_data_r};

  // A short link header leaves every other field clear.
  a_short_l2_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status == phc_pkg::STAT_SHORT_L2 |->
      out_data_r.ether_type == 16'd0 && out_data_r.l2_length == 5'd0 &&
      out_data_r.l3_kind == phc_pkg::KIND_NONE)
    else $error("short link header result carries link fields");

  // TCP flags only come with a complete TCP header.
  a_flags_tcp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.tcp_flag_bits != 6'd0 |->
      out_data_r.l4_protocol == phc_pkg::PROTO_TCP &&
      out_data_r.status == phc_pkg::STAT_OK)
    else $error("TCP flags reported for a non-TCP or short frame");

  // Back-pressure reaches the input only through a held last byte.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_valid_r && in_last_r && out_valid_r && !out_tready)
    else $error("input stalled without a pending result");

  // A result is loaded exactly when a last byte is taken.
  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    load_out_c |=> out_valid_r)
    else $error("last byte consumed without a result");

endmodule

`default_nettype wire

### rtl/core/phc_track.sv
`default_nettype none

module phc_track (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire logic [7:0]    data_byte,
  input  wire logic          last,
  output phc_pkg::track_t    trk
);

  localparam logic [7:0] POS_TYPE_HI  = 8'd12;
  localparam logic [7:0] POS_TYPE_LO  = 8'd13;
  localparam logic [7:0] POS_VLAN_HI  = 8'd16;
  localparam logic [7:0] POS_VLAN_LO  = 8'd17;
  localparam logic [7:0] POS_LAST     = 8'd255;
  localparam logic [7:0] REL_IP4_PROT = 8'd9;
  localparam logic [7:0] REL_IP6_NH   = 8'd6;
  localparam logic [7:0] L4_SPORT_HI  = 8'd0;
  localparam logic [7:0] L4_SPORT_LO  = 8'd1;
  localparam logic [7:0] L4_DPORT_HI  = 8'd2;
  localparam logic [7:0] L4_DPORT_LO  = 8'd3;
  localparam logic [7:0] L4_TCP_DOFF  = 8'd12;
  localparam logic [7:0] L4_TCP_FLAGS = 8'd13;

  phc_pkg::parse_state_t st_r;
  phc_pkg::parse_state_t st_nxt;
  phc_pkg::parse_state_t abs_c;
  logic [15:0] type_c;
  logic [15:0] vlan_type_c;
  logic [7:0]  rel_c;
  logic [7:0]  l4_pos_c;
  logic        l4_done_c;

  function automatic logic [2:0] kind_of(input logic [15:0] t);
    logic [2:0] k;
    if (t == phc_pkg::ETYPE_IPV4) begin
      k = phc_pkg::KIND_IPV4;
    end else if (t == phc_pkg::ETYPE_IPV6) begin
      k = phc_pkg::KIND_IPV6;
    end else if (t == phc_pkg::ETYPE_ARP) begin
      k = phc_pkg::KIND_ARP;
    end else begin
      k = phc_pkg::KIND_OTHER;
    end
    return k;
  endfunction

  // Fold the current byte into the header state.
  always_comb begin
    abs_c       = st_r;
    type_c      = {st_r.ether_type[7:0], data_byte};
    vlan_type_c = {st_r.vlan_hi, data_byte};
    rel_c       = st_r.pos - {3'b000, st_r.link_len};
    l4_pos_c    = st_r.pos - {1'b0, st_r.l4_off};
    l4_done_c   = 1'b0;

    if (st_r.pos inside {POS_TYPE_HI, POS_TYPE_LO}) begin
      abs_c.ether_type = type_c;
      if (st_r.pos == POS_TYPE_LO) begin
        abs_c.link_len = phc_pkg::ETH_LEN;
        abs_c.kind     = kind_of(type_c);
      end
    end else if (st_r.link_len == phc_pkg::ETH_LEN && st_r.ether_type == phc_pkg::TPID_VLAN)
    begin
      // Single VLAN tag: the inner type follows the tag control field.
      if (st_r.pos == POS_VLAN_HI) begin
        abs_c.vlan_hi = data_byte;
      end
      if (st_r.pos == POS_VLAN_LO) begin
        abs_c.ether_type = vlan_type_c;
        abs_c.link_len   = phc_pkg::VLAN_ETH_LEN;
        abs_c.kind       = kind_of(vlan_type_c);
      end
    end else if (st_r.link_len != 5'd0 && st_r.pos >= {3'b000, st_r.link_len}) begin
      case (st_r.kind)
        phc_pkg::KIND_IPV4: begin
          if (rel_c == 8'd0) begin
            abs_c.ihl_len = {data_byte[3:0], 2'b00};
            abs_c.l4_off  = {2'b00, st_r.link_len} + {1'b0, data_byte[3:0], 2'b00};
          end else if (rel_c == REL_IP4_PROT) begin
            abs_c.proto = data_byte;
          end
          l4_done_c = (rel_c != 8'd0) && (st_r.ihl_len >= phc_pkg::IP4_MIN_HDR) &&
                      (st_r.pos >= {1'b0, st_r.l4_off});
        end
        phc_pkg::KIND_IPV6: begin
          if (rel_c == 8'd0) begin
            abs_c.l4_off = {2'b00, st_r.link_len} + phc_pkg::IP6_HDR_LEN;
          end else if (rel_c == REL_IP6_NH) begin
            abs_c.proto = data_byte;
          end
          l4_done_c = rel_c >= {1'b0, phc_pkg::IP6_HDR_LEN};
        end
        default: begin
          l4_done_c = 1'b0;
        end
      endcase

      // Transport header capture.
      if (l4_done_c) begin
        if (st_r.proto == phc_pkg::PROTO_TCP || st_r.proto == phc_pkg::PROTO_UDP) begin
          if (l4_pos_c inside {L4_SPORT_HI, L4_SPORT_LO}) begin
            abs_c.sport = {st_r.sport[7:0], data_byte};
          end else if (l4_pos_c inside {L4_DPORT_HI, L4_DPORT_LO}) begin
            abs_c.dport = {st_r.dport[7:0], data_byte};
          end else if (st_r.proto == phc_pkg::PROTO_TCP && l4_pos_c == L4_TCP_DOFF) begin
            abs_c.tcp_len = {data_byte[7:4], 2'b00};
          end else if (st_r.proto == phc_pkg::PROTO_TCP && l4_pos_c == L4_TCP_FLAGS) begin
            abs_c.flags = data_byte[5:0];
          end
        end else if ((st_r.kind == phc_pkg::KIND_IPV4 && st_r.proto == phc_pkg::PROTO_ICMP) ||
                     (st_r.kind == phc_pkg::KIND_IPV6 && st_r.proto == phc_pkg::PROTO_ICMP6))
        begin
          if (l4_pos_c inside {L4_SPORT_HI, L4_SPORT_LO}) begin
            abs_c.icmp_bytes = {st_r.icmp_bytes[7:0], data_byte};
          end
        end
      end
    end

    // Byte counter saturates on very long frames.
    abs_c.pos = (st_r.pos == POS_LAST) ? st_r.pos : st_r.pos + 8'd1;
  end

  // The state returns to reset after the last byte of a frame.
  always_comb begin
    st_nxt = st_r;
    if (step) begin
      st_nxt = last ? '0 : abs_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign trk.frame_len = {1'b0, st_r.pos} + 9'd1;
  assign trk.hdr       = abs_c;

endmodule

`default_nettype wire

### rtl/core/phc_result.sv
`default_nettype none

module phc_result (
  input  wire phc_pkg::track_t  trk,
  output phc_pkg::result_t      res
);

  logic [8:0]  n_c;
  logic [8:0]  link_c;
  logic [8:0]  off_c;
  logic        l3_ok_c;
  logic        is_icmp_c;
  logic [15:0] sp_c;
  logic [15:0] dp_c;

  assign n_c    = trk.frame_len;
  assign link_c = {4'b0000, trk.hdr.link_len};
  assign off_c  = {2'b00, trk.hdr.l4_off};
  assign sp_c   = trk.hdr.sport;
  assign dp_c   = trk.hdr.dport;

  // Network header completeness.
  always_comb begin
    if (trk.hdr.kind == phc_pkg::KIND_IPV4) begin
      l3_ok_c = (n_c >= link_c + 9'd20) && (trk.hdr.ihl_len >= phc_pkg::IP4_MIN_HDR) &&
                (n_c >= link_c + {3'b000, trk.hdr.ihl_len});
    end else begin
      l3_ok_c = n_c >= link_c + {2'b00, phc_pkg::IP6_HDR_LEN};
    end
  end

  assign is_icmp_c =
      (trk.hdr.kind == phc_pkg::KIND_IPV4 && trk.hdr.proto == phc_pkg::PROTO_ICMP) ||
      (trk.hdr.kind == phc_pkg::KIND_IPV6 && trk.hdr.proto == phc_pkg::PROTO_ICMP6);

  // Assemble the result item.
  always_comb begin
    res = '0;
    if (n_c < {4'b0000, phc_pkg::ETH_LEN}) begin
      res.status = phc_pkg::STAT_SHORT_L2;
    end else begin
      res.ether_type = trk.hdr.ether_type;
      res.l2_length  = trk.hdr.link_len;
      res.l3_kind    = trk.hdr.kind;
      if (trk.hdr.kind == phc_pkg::KIND_IPV4 || trk.hdr.kind == phc_pkg::KIND_IPV6) begin
        if (!l3_ok_c) begin
          res.status = phc_pkg::STAT_SHORT_L3;
        end else begin
          res.l4_protocol = trk.hdr.proto;
          res.l4_offset   = trk.hdr.l4_off;
          if (trk.hdr.proto == phc_pkg::PROTO_TCP) begin
            if (n_c < off_c + phc_pkg::TCP_MIN_HDR ||
                n_c < off_c + {3'b000, trk.hdr.tcp_len}) begin
              res.status = phc_pkg::STAT_SHORT_L4;
            end else begin
              res.source_port   = sp_c;
              res.dest_port     = dp_c;
              res.tcp_flag_bits = trk.hdr.flags;
              res.app_mask[phc_pkg::APP_HTTP] =
                  (sp_c == phc_pkg::PORT_HTTP) || (dp_c == phc_pkg::PORT_HTTP);
              res.app_mask[phc_pkg::APP_FTP]  =
                  (sp_c == phc_pkg::PORT_FTP) || (dp_c == phc_pkg::PORT_FTP);
              res.app_mask[phc_pkg::APP_SMTP] =
                  (sp_c == phc_pkg::PORT_SMTP) || (dp_c == phc_pkg::PORT_SMTP);
            end
          end else if (trk.hdr.proto == phc_pkg::PROTO_UDP) begin
            if (n_c < off_c + phc_pkg::UDP_HDR_LEN) begin
              res.status = phc_pkg::STAT_SHORT_L4;
            end else begin
              res.source_port = sp_c;
              res.dest_port   = dp_c;
              res.app_mask[phc_pkg::APP_DNS]  =
                  (sp_c == phc_pkg::PORT_DNS) || (dp_c == phc_pkg::PORT_DNS);
              res.app_mask[phc_pkg::APP_DHCP] =
                  (sp_c == phc_pkg::PORT_DHCP_S) || (sp_c == phc_pkg::PORT_DHCP_C) ||
                  (dp_c == phc_pkg::PORT_DHCP_S) || (dp_c == phc_pkg::PORT_DHCP_C);
            end
          end else if (is_icmp_c) begin
            if (n_c < off_c + phc_pkg::ICMP_HDR_LEN) begin
              res.status = phc_pkg::STAT_SHORT_L4;
            end else begin
              res.icmp_kind    = trk.hdr.icmp_bytes[15:8];
              res.icmp_subcode = trk.hdr.icmp_bytes[7:0];
            end
          end
        end
      end
    end
  end

endmodule

`default_nettype wire
